/* rtl/trapezoid_motion_profile_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the trapezoid motion profile block
// Shared clocked assertion forms, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_MOTION_PROFILE_MACROS_SVH
`define TRAPEZOID_MOTION_PROFILE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define TMP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define TMP_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* rtl/tmp_pkg.sv */
// ----------------------------------------------------------------------------
// Trapezoid motion profile package
// Types, constants and helper functions shared by the profile modules.
// ----------------------------------------------------------------------------
package tmp_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ACCEL    = 2'd0;
  localparam logic [1:0] REG_VELOCITY = 2'd1;
  localparam logic [1:0] REG_DISTANCE = 2'd2;

  // Reset values of the limit registers (1.0 in Q16.16).
  localparam logic [30:0] ACCEL_RESET    = 31'd65536;
  localparam logic [30:0] VELOCITY_RESET = 31'd65536;

  // Queue between the classifier and the evaluator.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Profile segments.
  typedef enum logic [1:0] {
    STG_ACCEL = 2'd0,
    STG_COAST = 2'd1,
    STG_DECEL = 2'd2,
    STG_DONE  = 2'd3
  } stage_e;

  // Operations of the iterative arithmetic unit.
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_e;

  // Segment cutoffs and integration constants of the current move.
  typedef struct packed {
    logic [31:0] accel_end;
    logic [31:0] coast_end;
    logic [31:0] total_end;
    logic [47:0] coast_off;
    logic [47:0] decel_off;
    logic [46:0] v0_mag;
    logic        neg;
  } profile_t;

  // One classified time sample: multiplier operand x and span y.
  typedef struct packed {
    stage_e      stage;
    logic [31:0] x;
    logic [31:0] y;
  } item_t;

  // Clamp a 64-bit time to 32 bits.
  function automatic logic [31:0] sat_time(input logic [63:0] val);
    logic [31:0] res;
    res = (|val[63:32]) ? 32'hFFFF_FFFF : val[31:0];
    return res;
  endfunction

  // Apply the direction to a magnitude and saturate to the signed range.
  function automatic logic [31:0] sat_out(input logic [48:0] mag, input logic neg);
    logic [31:0] res;
    if (neg) begin
      res = (mag > 49'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end else begin
      res = (mag > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return res;
  endfunction

endpackage

/* rtl/tmp_arith.sv */
// ----------------------------------------------------------------------------
// Iterative arithmetic unit
// Bit-serial 64-bit multiply (low word), restoring divide and square root.
// ----------------------------------------------------------------------------
module tmp_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tmp_pkg::arith_op_e  op_i,
  input  logic [63:0]         opa_i,
  input  logic [63:0]         opb_i,
  output logic                done_o,
  output logic [63:0]         result_o
);

  logic               busy_q;
  logic               done_q;
  tmp_pkg::arith_op_e op_q;
  logic [63:0]        x_q, x_d;
  logic [63:0]        y_q, y_d;
  logic [64:0]        z_q, z_d;
  logic [5:0]         cnt_q;
  logic [64:0]        shifted_rem;
  logic [63:0]        trial;

  // One step of the selected operation.
  always_comb begin
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    shifted_rem = {z_q[63:0], x_q[63]};
    trial       = z_q[63:0] + y_q;
    case (op_q)
      tmp_pkg::OP_MUL: begin
        z_d = y_q[0] ? (z_q + {1'b0, x_q}) : z_q;
        x_d = {x_q[62:0], 1'b0};
        y_d = {1'b0, y_q[63:1]};
      end
      tmp_pkg::OP_DIV: begin
        if (shifted_rem >= {1'b0, y_q}) begin
          z_d = shifted_rem - {1'b0, y_q};
          x_d = {x_q[62:0], 1'b1};
        end else begin
          z_d = shifted_rem;
          x_d = {x_q[62:0], 1'b0};
        end
      end
      tmp_pkg::OP_SQRT: begin
        if (x_q >= trial) begin
          x_d = x_q - trial;
          z_d = {1'b0, {1'b0, z_q[63:1]} + y_q};
        end else begin
          z_d = {1'b0, 1'b0, z_q[63:1]};
        end
        y_d = {2'b00, y_q[63:2]};
      end
      default: begin
        z_d = z_q;
      end
    endcase
  end

  // Operand load and iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= tmp_pkg::OP_MUL;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        op_q   <= op_i;
        cnt_q  <= (op_i == tmp_pkg::OP_SQRT) ? 6'd31 : 6'd63;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= opa_i;
      y_q <= (op_i == tmp_pkg::OP_SQRT) ? 64'h4000_0000_0000_0000 : opb_i;
      z_q <= '0;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = (op_q == tmp_pkg::OP_DIV) ? x_q : z_q[63:0];

endmodule

/* rtl/tmp_derive.sv */
// ----------------------------------------------------------------------------
// Profile derivation sequencer
// Works out segment cutoffs and integration offsets after a register write.
// ----------------------------------------------------------------------------
module tmp_derive (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [30:0]       accel_i,
  input  logic [30:0]       velocity_i,
  input  logic [31:0]       distance_i,
  output logic              busy_o,
  output tmp_pkg::profile_t prof_o
);

  typedef enum logic [3:0] {
    D_IDLE, D_P1, D_P2, D_TDIV, D_TSQRT, D_Q1, D_TA, D_DC,
    D_TT, D_M1, D_M2, D_M3, D_M4
  } dstate_e;

  dstate_e            state_q;
  logic               issued_q;
  logic [63:0]        tmp_q;
  tmp_pkg::profile_t  prof_q;
  logic [31:0]        dm;
  logic               calc;
  logic               unit_start;
  tmp_pkg::arith_op_e unit_op;
  logic [63:0]        opa, opb;
  logic               unit_done;
  logic               step_done;
  logic [63:0]        unit_res;

  // Travel magnitude; the most negative distance maps onto 2^31 by itself.
  assign dm = distance_i[31] ? (32'd0 - distance_i) : distance_i;

  // Operands and operation of the current step.
  always_comb begin
    calc    = 1'b1;
    unit_op = tmp_pkg::OP_MUL;
    opa     = '0;
    opb     = '0;
    case (state_q)
      D_P1: begin
        opa = {32'd0, dm};
        opb = {33'd0, accel_i};
      end
      D_P2: begin
        opa = {33'd0, velocity_i};
        opb = {33'd0, velocity_i};
      end
      D_TDIV: begin
        unit_op = tmp_pkg::OP_DIV;
        opa     = {dm, 32'd0};
        opb     = {33'd0, accel_i};
      end
      D_TSQRT: begin
        unit_op = tmp_pkg::OP_SQRT;
        opa     = tmp_q;
      end
      D_Q1: begin
        unit_op = tmp_pkg::OP_DIV;
        opa     = tmp_q;
        opb     = {33'd0, accel_i};
      end
      D_TA: begin
        unit_op = tmp_pkg::OP_DIV;
        opa     = {17'd0, velocity_i, 16'd0};
        opb     = {33'd0, accel_i};
      end
      D_DC: begin
        unit_op = tmp_pkg::OP_DIV;
        opa     = {16'd0, dm - tmp_q[31:0], 16'd0};
        opb     = {33'd0, velocity_i};
      end
      D_M1: begin
        opa = {33'd0, accel_i};
        opb = {32'd0, prof_q.accel_end};
      end
      D_M2: begin
        opa = tmp_q;
        opb = {32'd0, prof_q.accel_end};
      end
      D_M3: begin
        opa = {33'd0, velocity_i};
        opb = {32'd0, prof_q.coast_end - prof_q.accel_end};
      end
      D_M4: begin
        opa = {33'd0, accel_i};
        opb = {32'd0, prof_q.total_end - prof_q.coast_end};
      end
      default: begin
        calc = 1'b0;
      end
    endcase
  end

  assign unit_start = calc && !issued_q;

  // Only a result of an operation issued by the current step counts.
  assign step_done = unit_done && issued_q;

  tmp_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (unit_start),
    .op_i     (unit_op),
    .opa_i    (opa),
    .opb_i    (opb),
    .done_o   (unit_done),
    .result_o (unit_res)
  );

  // Step sequence and derived values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= D_IDLE;
      issued_q <= 1'b0;
      tmp_q    <= '0;
      prof_q   <= '0;
    end else begin
      if (unit_start) begin
        issued_q <= 1'b1;
      end
      if (step_done) begin
        issued_q <= 1'b0;
      end
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            state_q <= D_P1;
          end
        end
        D_P1: begin
          if (step_done) begin
            tmp_q   <= unit_res;
            state_q <= D_P2;
          end
        end
        D_P2: begin
          if (step_done) begin
            if (tmp_q < unit_res) begin
              state_q <= D_TDIV;
            end else begin
              tmp_q   <= unit_res;
              state_q <= D_Q1;
            end
          end
        end
        D_TDIV: begin
          if (step_done) begin
            tmp_q   <= unit_res;
            state_q <= D_TSQRT;
          end
        end
        D_TSQRT: begin
          if (step_done) begin
            prof_q.accel_end <= unit_res[31:0];
            prof_q.coast_end <= unit_res[31:0];
            state_q          <= D_TT;
          end
        end
        D_Q1: begin
          if (step_done) begin
            tmp_q   <= unit_res;
            state_q <= D_TA;
          end
        end
        D_TA: begin
          if (step_done) begin
            prof_q.accel_end <= tmp_pkg::sat_time(unit_res);
            state_q          <= D_DC;
          end
        end
        D_DC: begin
          if (step_done) begin
            prof_q.coast_end <= tmp_pkg::sat_time({32'd0, prof_q.accel_end} + unit_res);
            state_q          <= D_TT;
          end
        end
        D_TT: begin
          prof_q.total_end <= tmp_pkg::sat_time({32'd0, prof_q.coast_end}
                                                + {32'd0, prof_q.accel_end});
          state_q          <= D_M1;
        end
        D_M1: begin
          if (step_done) begin
            tmp_q   <= {16'd0, unit_res[63:16]};
            state_q <= D_M2;
          end
        end
        D_M2: begin
          if (step_done) begin
            prof_q.coast_off <= {1'b0, unit_res[63:17]};
            state_q          <= D_M3;
          end
        end
        D_M3: begin
          if (step_done) begin
            prof_q.decel_off <= prof_q.coast_off + {1'b0, unit_res[62:16]};
            state_q          <= D_M4;
          end
        end
        D_M4: begin
          if (step_done) begin
            prof_q.v0_mag <= unit_res[62:16];
            prof_q.neg    <= distance_i[31];
            state_q       <= D_IDLE;
          end
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
      // A write during a derivation starts it over with the new values.
      if (start_i) begin
        state_q  <= D_P1;
        issued_q <= 1'b0;
      end
    end
  end

  assign busy_o = (state_q != D_IDLE);
  assign prof_o = prof_q;

endmodule

/* rtl/tmp_front.sv */
// ----------------------------------------------------------------------------
// Time sample classifier
// Accepts elapsed times and sorts them into profile segments.
// ----------------------------------------------------------------------------
module tmp_front (
  input  logic              s_valid_i,
  input  logic [31:0]       s_time_i,
  output logic              s_ready_o,
  input  logic              hold_i,
  input  logic              full_i,
  input  tmp_pkg::profile_t prof_i,
  output logic              push_o,
  output tmp_pkg::item_t    item_o
);

  // Take a word whenever the queue has room and no derivation or register write is under way.
  assign s_ready_o = !hold_i && !full_i;
  assign push_o    = s_valid_i && s_ready_o;

  // Segment and the spans that the evaluator multiplies.
  always_comb begin
    item_o.stage = tmp_pkg::STG_DONE;
    item_o.x     = '0;
    item_o.y     = '0;
    if (s_time_i <= prof_i.accel_end) begin
      item_o.stage = tmp_pkg::STG_ACCEL;
      item_o.x     = s_time_i;
      item_o.y     = s_time_i;
    end else if (s_time_i <= prof_i.coast_end) begin
      item_o.stage = tmp_pkg::STG_COAST;
      item_o.x     = s_time_i - prof_i.accel_end;
    end else if (s_time_i <= prof_i.total_end) begin
      item_o.stage = tmp_pkg::STG_DECEL;
      item_o.x     = prof_i.total_end - s_time_i;
      item_o.y     = s_time_i - prof_i.coast_end;
    end
  end

endmodule

/* rtl/tmp_queue.sv */
// ----------------------------------------------------------------------------
// Sample queue
// Short register queue between the classifier and the evaluator.
// ----------------------------------------------------------------------------
`include "trapezoid_motion_profile_macros.svh"

module tmp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tmp_pkg::item_t item_i,
  input  logic           pop_i,
  output tmp_pkg::item_t item_o,
  output logic           empty_o,
  output logic           full_o
);

  tmp_pkg::item_t                 mem_q [tmp_pkg::Q_DEPTH];
  logic [tmp_pkg::Q_PTR_W-1:0]    wr_q;
  logic [tmp_pkg::Q_PTR_W-1:0]    rd_q;
  logic [tmp_pkg::Q_CNT_W-1:0]    cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == tmp_pkg::Q_CNT_W'(tmp_pkg::Q_DEPTH));
  assign item_o  = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  `TMP_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o && !pop_i, "queue overflow")
  `TMP_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "queue underflow")
  `TMP_ASSERT(a_count_up, clk_i, rst_ni, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1), "queue count did not rise")
  `TMP_ASSERT(a_count_bound, clk_i, rst_ni, cnt_q <= tmp_pkg::Q_CNT_W'(tmp_pkg::Q_DEPTH), "queue count out of range")

endmodule

/* rtl/tmp_back.sv */
// ----------------------------------------------------------------------------
// Setpoint evaluator
// Pipelined position and velocity computation with an output register.
// ----------------------------------------------------------------------------
module tmp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tmp_pkg::item_t    item_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  logic [30:0]       accel_i,
  input  logic [30:0]       velocity_i,
  input  tmp_pkg::profile_t prof_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output tmp_pkg::stage_e   m_stage_o,
  output logic [31:0]       m_pos_o,
  output logic [31:0]       m_vel_o
);

  logic            adv;
  logic            v1_q, v2_q, v3_q, v4_q, out_v_q;
  tmp_pkg::stage_e s1_q, s2_q, s3_q, s4_q, out_s_q;
  logic [62:0]     m1_q;
  logic [31:0]     y1_q, y2_q;
  logic [47:0]     w2_q, w3_q, w4_q;
  logic [46:0]     vel2_q, vel3_q, vel4_q;
  logic [63:0]     pl3_q;
  logic [31:0]     ph3_q;
  logic [46:0]     sh4_q;
  logic [31:0]     pos_q, vel_q;

  logic [30:0]     opnd;
  logic [62:0]     mul1;
  logic [46:0]     vel_b2;
  logic [47:0]     w_b2;
  logic [46:0]     velo_b2;
  logic [63:0]     pl_b3;
  logic [47:0]     ph_b3;
  logic [63:0]     prod_b4;
  logic [48:0]     pos_mag;

  // The whole pipe moves when the output register is free or being taken.
  assign adv   = !out_v_q || m_ready_i;
  assign pop_o = adv && !empty_i;

  // Stage 1: rate times span.
  assign opnd = (item_i.stage == tmp_pkg::STG_COAST) ? velocity_i : accel_i;
  assign mul1 = opnd * item_i.x;

  // Stage 2: velocity magnitude and the factor for the position product.
  always_comb begin
    vel_b2  = m1_q[62:16];
    w_b2    = {1'b0, vel_b2};
    velo_b2 = vel_b2;
    case (s1_q)
      tmp_pkg::STG_COAST: begin
        velo_b2 = {16'd0, velocity_i};
      end
      tmp_pkg::STG_DECEL: begin
        w_b2 = {1'b0, prof_i.v0_mag} + {1'b0, vel_b2};
      end
      default: begin
        w_b2 = {1'b0, vel_b2};
      end
    endcase
  end

  // Stage 3: partial products of a 48 by 32 multiply, low word only.
  assign pl_b3 = w2_q[31:0] * y2_q;
  assign ph_b3 = w2_q[47:32] * y2_q;

  // Stage 4: combine the partial products and halve.
  assign prod_b4 = pl3_q + {ph3_q, 32'd0};

  // Output stage: add the segment offset.
  always_comb begin
    case (s4_q)
      tmp_pkg::STG_ACCEL: pos_mag = {2'b00, sh4_q};
      tmp_pkg::STG_COAST: pos_mag = {1'b0, prof_i.coast_off} + {1'b0, w4_q};
      tmp_pkg::STG_DECEL: pos_mag = {1'b0, prof_i.decel_off} + {2'b00, sh4_q};
      default:            pos_mag = '0;
    endcase
  end

  // Valid bits of the pipe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q    <= pop_o;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      out_v_q <= v4_q;
    end
  end

  // Payload of the pipe.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q    <= item_i.stage;
      m1_q    <= mul1;
      y1_q    <= item_i.y;
      s2_q    <= s1_q;
      w2_q    <= w_b2;
      vel2_q  <= velo_b2;
      y2_q    <= y1_q;
      s3_q    <= s2_q;
      w3_q    <= w2_q;
      vel3_q  <= vel2_q;
      pl3_q   <= pl_b3;
      ph3_q   <= ph_b3[31:0];
      s4_q    <= s3_q;
      w4_q    <= w3_q;
      vel4_q  <= vel3_q;
      sh4_q   <= prod_b4[63:17];
      out_s_q <= s4_q;
      if (s4_q == tmp_pkg::STG_DONE) begin
        pos_q <= '0;
        vel_q <= '0;
      end else begin
        pos_q <= tmp_pkg::sat_out(pos_mag, prof_i.neg);
        vel_q <= tmp_pkg::sat_out({2'b00, vel4_q}, prof_i.neg);
      end
    end
  end

  assign m_valid_o = out_v_q;
  assign m_stage_o = out_s_q;
  assign m_pos_o   = pos_q;
  assign m_vel_o   = vel_q;

endmodule

/* rtl/trapezoid_motion_profile.sv */
// ----------------------------------------------------------------------------
// Trapezoid motion profile
// Position and velocity setpoints of a trapezoidal move, one per time word.
// ----------------------------------------------------------------------------
// Usage: program accel_limit (0x0), velocity_limit (0x4) and move_distance
// (0x8) over the APB port while the block is idle. Each write starts a
// derivation of the segment cutoffs on a shared bit-serial multiply, divide
// and square-root unit, with at most nine operations on it; s_axis_tready
// stays low meanwhile. Input words on s_axis carry an elapsed time. Each
// yields one output word on m_axis: tuser holds the segment, tdata the
// position and velocity. Throughput is one word per cycle unless a
// derivation, a register write or a receiver stall holds the flow. An
// accepted word passes through the queue, four evaluator stages and the
// output register. When the receiver stalls, the evaluator pipe holds and the
// four-entry queue between classifier and evaluator fills before
// s_axis_tready drops. Reset restores limits of 1.0 and zero distance,
// clears the derived cutoffs and empties the pipe; no derivation is needed.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream, tdata: sample_time[31:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // Output stream, tdata: position[31:0], velocity[63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,
  // Output stream, tuser: stage[1:0]
  output logic [1:0]  m_axis_tuser,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [30:0]       accel_q;
  logic [30:0]       velocity_q;
  logic [31:0]       distance_q;
  logic [1:0]        reg_idx;
  logic              cfg_we;
  logic              derive_start;
  logic              derive_busy;
  logic [30:0]       accel_eff;
  logic [30:0]       velocity_eff;
  tmp_pkg::profile_t prof;
  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  logic              q_full;
  tmp_pkg::item_t    q_in;
  tmp_pkg::item_t    q_out;
  tmp_pkg::stage_e   out_stage;
  logic [31:0]       out_pos;
  logic [31:0]       out_vel;

  // Register access.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;
  assign derive_start = cfg_we && (reg_idx == tmp_pkg::REG_ACCEL
                                   || reg_idx == tmp_pkg::REG_VELOCITY
                                   || reg_idx == tmp_pkg::REG_DISTANCE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q    <= tmp_pkg::ACCEL_RESET;
      velocity_q <= tmp_pkg::VELOCITY_RESET;
      distance_q <= '0;
    end else if (cfg_we) begin
      case (reg_idx)
        tmp_pkg::REG_ACCEL:    accel_q    <= pwdata[30:0];
        tmp_pkg::REG_VELOCITY: velocity_q <= pwdata[30:0];
        tmp_pkg::REG_DISTANCE: distance_q <= pwdata;
        default:               accel_q    <= accel_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tmp_pkg::REG_ACCEL:    prdata = {1'b0, accel_q};
      tmp_pkg::REG_VELOCITY: prdata = {1'b0, velocity_q};
      tmp_pkg::REG_DISTANCE: prdata = distance_q;
      default:               prdata = '0;
    endcase
  end

  // A zero limit acts as one LSB.
  assign accel_eff    = (accel_q == '0) ? 31'd1 : accel_q;
  assign velocity_eff = (velocity_q == '0) ? 31'd1 : velocity_q;

  tmp_derive u_derive (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (derive_start),
    .accel_i    (accel_eff),
    .velocity_i (velocity_eff),
    .distance_i (distance_q),
    .busy_o     (derive_busy),
    .prof_o     (prof)
  );

  tmp_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_time_i  (s_axis_tdata),
    .s_ready_o (s_axis_tready),
    .hold_i    (derive_busy || cfg_we),
    .full_i    (q_full),
    .prof_i    (prof),
    .push_o    (q_push),
    .item_o    (q_in)
  );

  tmp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  tmp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (q_out),
    .empty_i    (q_empty),
    .pop_o      (q_pop),
    .accel_i    (accel_eff),
    .velocity_i (velocity_eff),
    .prof_i     (prof),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_stage_o  (out_stage),
    .m_pos_o    (out_pos),
    .m_vel_o    (out_vel)
  );

  assign m_axis_tdata = {out_vel, out_pos};
  assign m_axis_tuser = out_stage;

endmodule
